// ===== hw/rtl/lru_page_replacement_unit_assert.svh =====
// assertion macros shared by the checker of the lru page replacement unit
// depends on nothing; taken in by `include
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define LRU_PR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru page replacement check failed");

// next-cycle implication
`define LRU_PR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru page replacement check failed");

`endif

// ===== hw/rtl/lru_pr_pkg.sv =====
// constants, types and sequencer states of the lru page replacement unit
// depends on nothing
package lru_pr_pkg;

   localparam int FRAMES         = 8;
   localparam int PAGE_BITS      = 16;
   localparam int FRAME_IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_BITS      = FRAME_IDX_BITS;
   localparam int CSR_BITS       = 4;
   localparam int FAULT_BITS     = 32;

   localparam logic [CSR_BITS-1:0] CSR_RESET = CSR_BITS'(8);

   typedef logic [PAGE_BITS-1:0]      page_type;
   typedef logic [FRAME_IDX_BITS-1:0] frame_idx_type;
   typedef logic [RANK_BITS-1:0]      rank_type;
   typedef logic [FAULT_BITS-1:0]     fault_cnt_type;
   typedef logic [CSR_BITS-1:0]       csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE
   } state_type;

endpackage

// ===== hw/rtl/lru_pr_intf.sv =====
// valid/ready channel interfaces of the lru page replacement unit
// depends on lru_pr_pkg
interface lru_pr_req_if;
   logic                 valid;
   logic                 ready;
   lru_pr_pkg::page_type page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_pr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      is_fault;
   lru_pr_pkg::frame_idx_type frame_used;
   lru_pr_pkg::page_type      evicted_page;
   lru_pr_pkg::fault_cnt_type faults_so_far;

   modport source (output valid, output is_fault, output frame_used, output evicted_page,
                   output faults_so_far, input ready);
   modport sink   (input valid, input is_fault, input frame_used, input evicted_page,
                   input faults_so_far, output ready);
endinterface

interface lru_pr_csr_if;
   logic                valid;
   logic                ready;
   lru_pr_pkg::csr_type frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface

// ===== hw/rtl/lru_page_replacement_unit.sv =====
// top level of the lru page replacement unit: frame table, rank array, scan sequencer
// depends on lru_pr_pkg and the channel interfaces in lru_pr_intf.sv
//
// One page reference per req word, one rsp word per reference. A reference is accepted
// in IDLE; SCAN then sweeps the frames in use (frames_in_use clamped to 1..FRAMES) through
// the single read port of the frame table, past one comparator; WAIT lets the last compare
// land; DECIDE picks the frame, updates ranks and loads the result. Page zero skips the
// sweep and goes from IDLE straight to DECIDE. The result sits in an output
// register, so the next reference is taken while a result still waits; the decision
// cycle stalls only if that register is still full. Frames come out of reset empty by way
// of per-frame valid bits, so no clearing pass is run. frames_in_use is written through
// csr_chan, always ready, and should only change while the unit is idle.
module lru_page_replacement_unit (
   input  logic              clock,
   input  logic              reset,
   lru_pr_req_if.sink        req_chan,
   lru_pr_rsp_if.source      rsp_chan,
   lru_pr_csr_if.sink        csr_chan
);

   // sequencer
   lru_pr_pkg::state_type     state_ff, state_in;
   logic                      req_acc;
   logic                      rd_en;
   logic                      decide_go;

   // captured reference and scan bounds
   lru_pr_pkg::page_type      page_ff;
   logic                      zero_ff;
   lru_pr_pkg::frame_idx_type last_ff, last_in;
   lru_pr_pkg::frame_idx_type iss_ff;
   lru_pr_pkg::csr_type       frames_ff;

   // frame table: memory plus per-frame valid bits (invalid reads as empty)
   lru_pr_pkg::page_type      page_mem [lru_pr_pkg::FRAMES];
   logic [lru_pr_pkg::FRAMES-1:0] page_vld_ff;
   lru_pr_pkg::page_type      rd_data_ff;
   logic                      rd_ok_ff;
   logic                      cmp_vld_ff;
   lru_pr_pkg::frame_idx_type cmp_idx_ff;
   lru_pr_pkg::page_type      cmp_page;
   lru_pr_pkg::rank_type      cmp_rank;

   // recency ranks, one register per frame
   lru_pr_pkg::rank_type      rank_ff [lru_pr_pkg::FRAMES];

   // scan results
   logic                      hit_found_ff;
   lru_pr_pkg::frame_idx_type hit_idx_ff;
   lru_pr_pkg::rank_type      hit_rank_ff;
   logic                      empty_found_ff;
   lru_pr_pkg::frame_idx_type empty_idx_ff;
   lru_pr_pkg::rank_type      empty_rank_ff;
   lru_pr_pkg::frame_idx_type min_idx_ff;
   lru_pr_pkg::rank_type      min_rank_ff;
   lru_pr_pkg::page_type      min_page_ff;

   // decision
   lru_pr_pkg::frame_idx_type used_idx;
   lru_pr_pkg::rank_type      used_rank;
   logic                      do_touch;
   logic                      do_fill;
   lru_pr_pkg::page_type      evicted;
   lru_pr_pkg::fault_cnt_type fault_total_ff, fault_total_in;

   // result register
   logic                      rsp_vld_ff;
   logic                      rsp_fault_ff;
   lru_pr_pkg::frame_idx_type rsp_frame_ff;
   lru_pr_pkg::page_type      rsp_evict_ff;
   lru_pr_pkg::fault_cnt_type rsp_count_ff;

   // handshakes
   assign req_acc               = req_chan.valid && req_chan.ready;
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.is_fault     = rsp_fault_ff;
   assign rsp_chan.frame_used   = rsp_frame_ff;
   assign rsp_chan.evicted_page = rsp_evict_ff;
   assign rsp_chan.faults_so_far = rsp_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lru_pr_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_chan.page_number == '0) ? lru_pr_pkg::ST_DECIDE
                                                       : lru_pr_pkg::ST_SCAN;
            end
         end
         lru_pr_pkg::ST_SCAN: begin
            if (iss_ff == last_ff) begin
               state_in = lru_pr_pkg::ST_WAIT;
            end
         end
         lru_pr_pkg::ST_WAIT: begin
            state_in = lru_pr_pkg::ST_DECIDE;
         end
         lru_pr_pkg::ST_DECIDE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               state_in = lru_pr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lru_pr_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      decide_go      = 1'b0;
      case (state_ff)
         lru_pr_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         lru_pr_pkg::ST_SCAN:   rd_en = 1'b1;
         lru_pr_pkg::ST_WAIT:   rd_en = 1'b0;
         lru_pr_pkg::ST_DECIDE: decide_go = !rsp_vld_ff || rsp_chan.ready;
         default:               rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lru_pr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // frame count register, clamped to 1..FRAMES when a reference starts
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= lru_pr_pkg::CSR_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         frames_ff <= csr_chan.frames_in_use;
      end
   end

   always_comb begin
      if (frames_ff == '0) begin
         last_in = '0;
      end else if (32'(frames_ff) > 32'(lru_pr_pkg::FRAMES)) begin
         last_in = lru_pr_pkg::FRAME_IDX_BITS'(lru_pr_pkg::FRAMES - 1);
      end else begin
         last_in = lru_pr_pkg::FRAME_IDX_BITS'(32'(frames_ff) - 32'd1);
      end
   end

   // reference capture and sweep address
   always_ff @(posedge clock) begin
      if (req_acc) begin
         page_ff <= req_chan.page_number;
         zero_ff <= (req_chan.page_number == '0);
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= '0;
      end else if (req_acc) begin
         iss_ff <= '0;
      end else if (rd_en && iss_ff != last_ff) begin
         iss_ff <= iss_ff + 1'b1;
      end
   end

   // frame table read port (registered) and write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= page_mem[iss_ff];
      end
      if (do_fill) begin
         page_mem[used_idx] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_vld_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_en;
         if (do_fill) begin
            page_vld_ff[used_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ok_ff   <= page_vld_ff[iss_ff];
         cmp_idx_ff <= iss_ff;
      end
   end

   // shared compare: one frame per cycle
   assign cmp_page = rd_ok_ff ? rd_data_ff : '0;
   assign cmp_rank = rank_ff[cmp_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (req_acc) begin
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (cmp_vld_ff) begin
         if (!hit_found_ff && cmp_page == page_ff) begin
            hit_found_ff <= 1'b1;
         end
         if (!empty_found_ff && cmp_page == '0) begin
            empty_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_vld_ff) begin
         if (!hit_found_ff && cmp_page == page_ff) begin
            hit_idx_ff  <= cmp_idx_ff;
            hit_rank_ff <= cmp_rank;
         end
         if (!empty_found_ff && cmp_page == '0) begin
            empty_idx_ff  <= cmp_idx_ff;
            empty_rank_ff <= cmp_rank;
         end
         // strict less keeps the lowest-numbered frame on a rank tie
         if (cmp_idx_ff == '0 || cmp_rank < min_rank_ff) begin
            min_idx_ff  <= cmp_idx_ff;
            min_rank_ff <= cmp_rank;
            min_page_ff <= cmp_page;
         end
      end
   end

   // pick the frame: page zero reports frame 0, else hit, else first empty, else least recently used
   always_comb begin
      used_rank = min_rank_ff;
      evicted   = '0;
      if (zero_ff) begin
         used_idx = '0;
      end else if (hit_found_ff) begin
         used_idx  = hit_idx_ff;
         used_rank = hit_rank_ff;
      end else if (empty_found_ff) begin
         used_idx  = empty_idx_ff;
         used_rank = empty_rank_ff;
      end else begin
         used_idx = min_idx_ff;
         evicted  = min_page_ff;
      end
   end

   assign do_touch = decide_go && !zero_ff;
   assign do_fill  = do_touch && !hit_found_ff;

   assign fault_total_in = (fault_total_ff == '1) ? fault_total_ff
                                                  : fault_total_ff + 1'b1;

   // rank refresh: touched frame goes to the top, those above its old rank slide down
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
            rank_ff[g] <= '0;
         end
      end else if (do_touch) begin
         for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
            if (lru_pr_pkg::FRAME_IDX_BITS'(g) == used_idx) begin
               rank_ff[g] <= lru_pr_pkg::RANK_BITS'(lru_pr_pkg::FRAMES - 1);
            end else if (rank_ff[g] > used_rank) begin
               rank_ff[g] <= rank_ff[g] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_total_ff <= '0;
      end else if (do_fill) begin
         fault_total_ff <= fault_total_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (decide_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_go) begin
         rsp_fault_ff <= !zero_ff && !hit_found_ff;
         rsp_frame_ff <= used_idx;
         rsp_evict_ff <= zero_ff ? '0 : evicted;
         rsp_count_ff <= do_fill ? fault_total_in : fault_total_ff;
      end
   end

endmodule

// ===== hw/rtl/lru_pr_checker.sv =====
// port-level checks for the lru page replacement unit, bound to its top level
// depends on lru_pr_pkg and lru_page_replacement_unit_assert.svh
`include "lru_page_replacement_unit_assert.svh"

module lru_pr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_is_fault,
   input lru_pr_pkg::frame_idx_type rsp_frame_used,
   input lru_pr_pkg::page_type      rsp_evicted_page,
   input lru_pr_pkg::fault_cnt_type rsp_faults_so_far
);

   logic [1:0]                cnt_ff, cnt_in;
   lru_pr_pkg::fault_cnt_type prev_ff;
   logic                      req_acc;
   logic                      rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign cnt_in  = cnt_ff + {1'b0, req_acc} - {1'b0, rsp_acc};

   // words accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // last fault count delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (rsp_acc) begin
         prev_ff <= rsp_faults_so_far;
      end
   end

   `LRU_PR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_is_fault) && $stable(rsp_frame_used) &&
      $stable(rsp_evicted_page) && $stable(rsp_faults_so_far))

   `LRU_PR_ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, cnt_ff != 2'd0)

   `LRU_PR_ASSERT_IMPL(a_fault_step, clock, reset, rsp_acc,
      (!rsp_is_fault && rsp_faults_so_far == prev_ff) ||
      (rsp_is_fault && (rsp_faults_so_far == prev_ff + 32'd1 ||
      (prev_ff == 32'hFFFF_FFFF && rsp_faults_so_far == prev_ff))))

   `LRU_PR_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_valid && !rsp_is_fault,
      rsp_evicted_page == '0)

endmodule

bind lru_page_replacement_unit lru_pr_checker u_lru_pr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_is_fault      (rsp_chan.is_fault),
   .rsp_frame_used    (rsp_chan.frame_used),
   .rsp_evicted_page  (rsp_chan.evicted_page),
   .rsp_faults_so_far (rsp_chan.faults_so_far)
);

// ===== dv/lru_page_replacement_unit_tb.sv =====
// testbench of the lru page replacement unit: random page references against a lru predictor
// depends on lru_pr_pkg and the req/rsp/csr channel interfaces from lru_pr_intf.sv
module lru_page_replacement_unit_tb;

   localparam int CLK_HALF       = 2;
   localparam int RESET_CYCLES   = 12;
   localparam int ITEM_TARGET    = 1250;
   localparam int SETTLE_CYCLES  = lru_pr_pkg::FRAMES + 8;
   localparam int TIMEOUT_CYCLES = 600_000;
   localparam int POOL_MAX       = 12;

   // one rsp word as the unit reports it
   typedef struct packed {
      logic                      is_fault;
      lru_pr_pkg::frame_idx_type frame_used;
      lru_pr_pkg::page_type      evicted_page;
      lru_pr_pkg::fault_cnt_type faults_so_far;
   } lookup_word_type;

   // keeps its own frame table, ranks and fault count, and queues the word each
   // accepted reference should produce
   class lru_frame_scoreboard;
      lru_pr_pkg::page_type      frame_page[lru_pr_pkg::FRAMES];
      lru_pr_pkg::rank_type      frame_rank[lru_pr_pkg::FRAMES];
      lru_pr_pkg::fault_cnt_type fault_total;
      lru_pr_pkg::csr_type       frame_count;
      lookup_word_type           expected_words[$];
      int unsigned               mismatches;

      function new();
         foreach (frame_page[i]) begin
            frame_page[i] = '0;
            frame_rank[i] = '0;
         end
         fault_total = '0;
         frame_count = lru_pr_pkg::CSR_RESET;
         mismatches  = 0;
      endfunction

      function void set_frame_count(lru_pr_pkg::csr_type value);
         frame_count = value;
      endfunction

      // count of 0 behaves as 1, anything above the built size as the built size
      function int active_frames();
         int n;
         n = int'(frame_count);
         if (n < 1) n = 1;
         if (n > lru_pr_pkg::FRAMES) n = lru_pr_pkg::FRAMES;
         return n;
      endfunction

      function void note_reference(lru_pr_pkg::page_type pg);
         lookup_word_type      w;
         int                   n;
         int                   i;
         int                   used;
         bit                   found;
         bit                   empty;
         lru_pr_pkg::rank_type old_rank;
         n     = active_frames();
         used  = 0;
         found = 0;
         empty = 0;
         w     = '0;
         if (pg != '0) begin
            // hit search, lowest frame wins when a page sits twice
            for (i = 0; i < n; i++) begin
               if (!found && frame_page[i] == pg) begin
                  used  = i;
                  found = 1;
               end
            end
            if (!found) begin
               w.is_fault = 1'b1;
               for (i = 0; i < n; i++) begin
                  if (!empty && frame_page[i] == '0) begin
                     used  = i;
                     empty = 1;
                  end
               end
               if (!empty) begin
                  // least recent in use, ties to the lowest frame
                  used = 0;
                  for (i = 1; i < n; i++) begin
                     if (frame_rank[i] < frame_rank[used]) used = i;
                  end
                  w.evicted_page = frame_page[used];
               end
               frame_page[used] = pg;
               if (fault_total != '1) fault_total++;
            end
            // ranks age across every frame, in use or not
            old_rank = frame_rank[used];
            for (i = 0; i < lru_pr_pkg::FRAMES; i++) begin
               if (i != used && frame_rank[i] > old_rank) frame_rank[i]--;
            end
            frame_rank[used] = lru_pr_pkg::rank_type'(lru_pr_pkg::FRAMES - 1);
         end
         w.frame_used    = lru_pr_pkg::frame_idx_type'(used);
         w.faults_so_far = fault_total;
         expected_words.push_back(w);
      endfunction

      function void field_error(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_word(lookup_word_type got);
         lookup_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: rsp word with nothing expected, expected none, actual %h",
                     $time, got);
            return;
         end
         want = expected_words.pop_front();
         if (got.is_fault !== want.is_fault)
            field_error("is_fault", 32'(want.is_fault), 32'(got.is_fault));
         if (got.frame_used !== want.frame_used)
            field_error("frame_used", 32'(want.frame_used), 32'(got.frame_used));
         if (got.evicted_page !== want.evicted_page)
            field_error("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
         if (got.faults_so_far !== want.faults_so_far)
            field_error("faults_so_far", want.faults_so_far, got.faults_so_far);
      endfunction
   endclass

   logic clock;
   logic reset;

   lru_pr_req_if req_if();
   lru_pr_rsp_if rsp_if();
   lru_pr_csr_if csr_if();

   lru_page_replacement_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   lru_frame_scoreboard  frame_tracker;
   bit                   steady;          // phase with no idling on either side
   int unsigned          sent_count;
   int                   stall_left = 0;
   int                   pool_size = 1;
   lru_pr_pkg::page_type working_set[POOL_MAX];

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // mostly no gap, sometimes a short one, rarely a long one; none in a steady phase
   function automatic int idle_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // references mostly hit a small working set so hits and evictions both occur,
   // the rest are wide random pages, page zero and single-bit or all-ones pages
   function automatic lru_pr_pkg::page_type pick_page();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 78) return working_set[$urandom_range(0, pool_size - 1)];
      if (roll < 92) return lru_pr_pkg::page_type'($urandom_range(1, 65535));
      if (roll < 96) return '0;
      if ($urandom_range(0, 1) == 0) return '1;
      return lru_pr_pkg::page_type'(1) << $urandom_range(0, lru_pr_pkg::PAGE_BITS - 1);
   endfunction

   // rsp side back-pressure, changes at the falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready = 1'b1;
         stall_left = idle_gap();
      end
   end

   // all handshakes are seen at the rising edge: results checked, references and
   // register writes fed to the predictor in the order the unit takes them
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            frame_tracker.check_word({rsp_if.is_fault, rsp_if.frame_used,
                                      rsp_if.evicted_page, rsp_if.faults_so_far});
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            frame_tracker.note_reference(req_if.page_number);
         if (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)
            frame_tracker.set_frame_count(csr_if.frames_in_use);
      end
   end

   // one req word; valid stays high into the next word when there is no gap
   task automatic send_page(input lru_pr_pkg::page_type pg);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_if.valid       = 1'b0;
         req_if.page_number = lru_pr_pkg::page_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.page_number = pg;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
      sent_count++;
   endtask

   // stop sending, let every expected word come back, then let the unit settle
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (frame_tracker.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_frame_count(input lru_pr_pkg::csr_type value);
      wait_idle();
      csr_if.valid         = 1'b1;
      csr_if.frames_in_use = value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   initial begin
      lru_pr_pkg::page_type fill_pages[13];
      lru_pr_pkg::csr_type  phase_counts[12];
      lru_pr_pkg::csr_type  count;
      int                   phase;
      int                   items;
      int                   active;

      fill_pages   = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h5555,
                       16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFE, 16'h0001,
                       16'hFFFF, 16'h1234, 16'h0000};
      phase_counts = '{4'd1, 4'd8, 4'd4, 4'd9, 4'd0, 4'd15, 4'd6, 4'd2, 4'd7, 4'd3,
                       4'd5, 4'd8};

      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.page_number   = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.frames_in_use = lru_pr_pkg::CSR_RESET;
      steady               = 1'b0;
      sent_count           = 0;
      frame_tracker        = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset count of eight: page zero on an empty table, fill every frame with
      // edge pages, two hits, an eviction of the oldest, page zero again at the end
      foreach (fill_pages[i]) send_page(fill_pages[i]);
      // shrink to two: pages living in frames outside the count miss and get a
      // second copy inside it
      write_frame_count(4'd2);
      send_page(16'hAAAA);
      send_page(16'h5555);
      // count above the built size acts as eight: duplicates hit the lower frame
      write_frame_count(4'd15);
      send_page(16'hAAAA);
      send_page(16'h5555);
      // count of zero acts as one
      write_frame_count(4'd0);
      send_page(16'h0F0F);
      send_page(16'h0F0F);
      send_page(16'hF0F0);
      // fault count saturation would need four billion faults, out of reach here

      // random phases, each with its own frame count and working set
      phase = 0;
      while (sent_count < ITEM_TARGET) begin
         count = (phase < 12) ? phase_counts[phase]
                              : lru_pr_pkg::csr_type'($urandom_range(0, 15));
         write_frame_count(count);
         active = (count == 0) ? 1 :
                  (int'(count) > lru_pr_pkg::FRAMES) ? lru_pr_pkg::FRAMES : int'(count);
         pool_size = active + $urandom_range(0, 4);
         if (pool_size > POOL_MAX) pool_size = POOL_MAX;
         foreach (working_set[i])
            working_set[i] = lru_pr_pkg::page_type'($urandom_range(1, 65535));
         steady = ($urandom_range(0, 3) == 0);
         items  = $urandom_range(60, 140);
         repeat (items) send_page(pick_page());
         phase++;
      end

      steady = 1'b0;
      wait_idle();
      if (frame_tracker.mismatches == 0 && frame_tracker.expected_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hard stop in case the unit hangs
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLK_HALF);
      $display("FAILURE");
      $finish;
   end

endmodule
